FILE: rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions of the position region classifier
// Field widths, register indexes, region codes and map geometry constants.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int REGION_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 32;
  localparam int IN_TDATA_W = 64;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 8;

  typedef logic [REGION_W-1:0] region_t;

  localparam region_t REGION_UNKNOWN = 3'd0;
  localparam region_t REGION_LEFT_UP = 3'd1;
  localparam region_t REGION_LEFT_LO = 3'd2;
  localparam region_t REGION_DROP    = 3'd3;
  localparam region_t REGION_MIDDLE  = 3'd4;
  localparam region_t REGION_RIGHT   = 3'd5;
  localparam region_t REGION_OTHER   = 3'd6;
  localparam region_t REGION_MAX     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_EAST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_NORTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPM          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST      = 3'd5;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PIX_FRAC = 8;

  // Map geometry; the box limits and the ellipse centre are in Q.8 pixels.
  localparam logic signed [PROD_W-1:0] RIGHT_U_MIN  = PROD_W'(415 * 256);
  localparam logic signed [PROD_W-1:0] MIDDLE_U_MIN = PROD_W'(300 * 256);
  localparam logic signed [PROD_W-1:0] UPPER_V_MAX  = PROD_W'(315 * 256);
  localparam logic signed [PROD_W-1:0] LOWER_U_MAX  = PROD_W'(300 * 256);
  localparam logic signed [PROD_W-1:0] LOWER_V_MIN  = PROD_W'(190 * 256);
  localparam logic signed [PROD_W-1:0] UPPER_U_MAX  = PROD_W'(245 * 256);
  localparam logic signed [PROD_W-1:0] UPPERL_V_MAX = PROD_W'(215 * 256);
  localparam logic signed [MUL_A_W-1:0] DROP_CU = MUL_A_W'(285 * 256);
  localparam logic signed [MUL_A_W-1:0] DROP_CV = MUL_A_W'(225 * 256);
  localparam logic signed [MUL_B_W-1:0] DROP_RU = MUL_B_W'(52);
  localparam logic signed [MUL_B_W-1:0] DROP_RV = MUL_B_W'(66);
  localparam longint DROP_RAD = 52 * 66 * 256;
  localparam logic [PROD_W-1:0] DROP_RAD_SQ = PROD_W'(DROP_RAD * DROP_RAD);

endpackage

FILE: rtl/core/position_region_classifier_unit.sv
// ----------------------------------------------------------------------------
// position_region_classifier_unit: map region classifier with persistence
// Converts a position to map pixels, sorts it into a region and filters it.
// ----------------------------------------------------------------------------
// A position transaction steps through the states MX, MY, V, CHK, EV, QU, QV,
// CMP and FLT before the next one can be accepted; a position that lands off
// the map goes from CHK to FLT, and a force command or a non-finite position
// from IDLE to FLT. The sequence comes from one shared 33 by 28 bit signed
// multiplier that a sequencer steps through six products in turn: the two
// pixel scalings, the two ellipse axis weightings and the two squares. A
// result waits in the output register while the next transaction is taken.
module position_region_classifier_unit #(
  parameter int POS_FRAC_BITS = 16,
  parameter int COUNT_BITS    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32].
  input  logic [prc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // Fields from bit 0: cmd[0], pos_finite[1].
  input  logic [prc_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Fields from bit 0: raw_region[2:0], region[5:3], zero padding[7:6].
  output logic [prc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import prc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MX   = 4'd1;
  localparam logic [3:0] ST_MY   = 4'd2;
  localparam logic [3:0] ST_V    = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_EV   = 4'd5;
  localparam logic [3:0] ST_QU   = 4'd6;
  localparam logic [3:0] ST_QV   = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_FLT  = 4'd9;

  logic signed [POS_W-1:0] origin_east_q, origin_north_q;
  logic [15:0]             ppm_q;
  logic [11:0]             map_width_q, map_height_q;
  logic [7:0]              persist_q;

  logic [3:0]                  state_q, state_d;
  logic signed [MUL_A_W-1:0]   dx_q, dy_q;
  logic signed [PROD_W-1:0]    prod_q, u_q, v_q;
  logic [PROD_W-1:0]           sq_q;
  logic signed [MUL_B_W-1:0]   eu_q, ev_q;
  region_t                     box_q, raw_q;
  logic                        cmd_q;

  region_t                 acc_q, cand_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic                    started_q;

  logic                    out_valid_q;
  region_t                 out_raw_q, out_region_q;

  logic                        s_hs, out_free, off_map;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    mul_p, u_lim, v_lim, v_d;
  logic [PROD_W-1:0]           sq_sum;
  region_t                     box;
  logic [COUNT_BITS-1:0]       cnt_inc, cnt_new;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_region_q, out_raw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_east_q  <= -32'sd997291;
      origin_north_q <= -32'sd204640;
      ppm_q          <= 16'd5120;
      map_width_q    <= 12'd615;
      map_height_q   <= 12'd403;
      persist_q      <= 8'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_EAST:  origin_east_q  <= cfg_data_i;
        REG_ORIGIN_NORTH: origin_north_q <= cfg_data_i;
        REG_PPM:          ppm_q          <= cfg_data_i[15:0];
        REG_MAP_WIDTH:    map_width_q    <= cfg_data_i[11:0];
        REG_MAP_HEIGHT:   map_height_q   <= cfg_data_i[11:0];
        REG_PERSIST:      persist_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      ST_MX: begin
        mul_a = dx_q;
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, ppm_q});
      end
      ST_MY: begin
        mul_a = dy_q;
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, ppm_q});
      end
      ST_CHK: begin
        mul_a = u_q[MUL_A_W-1:0] - DROP_CU;
        mul_b = DROP_RV;
      end
      ST_EV: begin
        mul_a = v_q[MUL_A_W-1:0] - DROP_CV;
        mul_b = DROP_RU;
      end
      ST_QU: begin
        mul_a = MUL_A_W'(eu_q);
        mul_b = eu_q;
      end
      ST_QV: begin
        mul_a = MUL_A_W'(ev_q);
        mul_b = ev_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign u_lim  = $signed({{(PROD_W-12-PIX_FRAC){1'b0}}, map_width_q, {PIX_FRAC{1'b0}}});
  assign v_lim  = $signed({{(PROD_W-12-PIX_FRAC){1'b0}}, map_height_q, {PIX_FRAC{1'b0}}});
  assign v_d    = v_lim - (prod_q >>> POS_FRAC_BITS);
  assign off_map = u_q[PROD_W-1] || (u_q >= u_lim) || v_q[PROD_W-1] || (v_q >= v_lim);
  assign sq_sum = sq_q + prod_q;

  always_comb begin
    box = REGION_OTHER;
    if (u_q >= RIGHT_U_MIN && v_q < UPPER_V_MAX) box = REGION_RIGHT;
    if (u_q >= MIDDLE_U_MIN && u_q < RIGHT_U_MIN && v_q < UPPER_V_MAX) box = REGION_MIDDLE;
    if (u_q < LOWER_U_MAX && v_q >= LOWER_V_MIN) box = REGION_LEFT_LO;
    if (u_q < UPPER_U_MAX && v_q < UPPERL_V_MAX) box = REGION_LEFT_UP;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (s_axis_tuser_i[0] || !s_axis_tuser_i[1]) state_d = ST_FLT;
          else state_d = ST_MX;
        end
      end
      ST_MX:  state_d = ST_MY;
      ST_MY:  state_d = ST_V;
      ST_V:   state_d = ST_CHK;
      ST_CHK: state_d = off_map ? ST_FLT : ST_EV;
      ST_EV:  state_d = ST_QU;
      ST_QU:  state_d = ST_QV;
      ST_QV:  state_d = ST_CMP;
      ST_CMP: state_d = ST_FLT;
      ST_FLT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        dx_q  <= MUL_A_W'(signed'(s_axis_tdata_i[31:0])) - MUL_A_W'(origin_east_q);
        dy_q  <= MUL_A_W'(signed'(s_axis_tdata_i[63:32])) - MUL_A_W'(origin_north_q);
        cmd_q <= s_axis_tuser_i[0];
        raw_q <= REGION_UNKNOWN;
      end
      ST_MX: prod_q <= mul_p;
      ST_MY: begin
        u_q    <= prod_q >>> POS_FRAC_BITS;
        prod_q <= mul_p;
      end
      ST_V: v_q <= v_d;
      ST_CHK: begin
        prod_q <= mul_p;
        box_q  <= box;
      end
      ST_EV: begin
        eu_q   <= prod_q[MUL_B_W-1:0];
        prod_q <= mul_p;
      end
      ST_QU: begin
        ev_q   <= prod_q[MUL_B_W-1:0];
        prod_q <= mul_p;
      end
      ST_QV: begin
        sq_q   <= prod_q;
        prod_q <= mul_p;
      end
      ST_CMP: raw_q <= (sq_sum <= DROP_RAD_SQ) ? REGION_DROP : box_q;
      default: ;
    endcase
  end

  assign cnt_inc = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign cnt_new = (raw_q == cand_q) ? cnt_inc : COUNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= REGION_UNKNOWN;
      cand_q      <= REGION_UNKNOWN;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_FLT && out_free) begin
        out_valid_q <= 1'b1;
        started_q   <= 1'b1;
        priority if (cmd_q) begin
          acc_q  <= REGION_UNKNOWN;
          cand_q <= REGION_UNKNOWN;
          cnt_q  <= '0;
        end else if (!started_q || raw_q == acc_q) begin
          acc_q  <= raw_q;
          cand_q <= raw_q;
          cnt_q  <= '0;
        end else begin
          cand_q <= raw_q;
          if (CMP_W'(cnt_new) >= CMP_W'(persist_q)) begin
            acc_q <= raw_q;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_new;
          end
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLT && out_free) begin
      out_raw_q <= raw_q;
      priority if (cmd_q || !started_q || raw_q == acc_q) begin
        out_region_q <= raw_q;
      end else if (CMP_W'(cnt_new) >= CMP_W'(persist_q)) begin
        out_region_q <= raw_q;
      end else begin
        out_region_q <= acc_q;
      end
    end
  end

endmodule

FILE: rtl/core/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker: port level checks of the position region classifier
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [prc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input logic [prc_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [prc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import prc_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i)
                     ^ (^s_axis_tdata_i) ^ (^s_axis_tuser_i);

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a transaction is in progress");

  a_region_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= REGION_MAX &&
                         m_axis_tdata_o[5:3] <= REGION_MAX))
    else $error("region code out of range");

  a_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:6] == 2'b00))
    else $error("output padding bits not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output changed");

endmodule

bind position_region_classifier_unit prc_checker u_prc_checker (.*);

FILE: bench/tb_position_region_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_position_region_classifier_unit: self-checking bench for the classifier
// Position samples and force commands are streamed in with random gaps and
// checked against an in-bench model of the pixel mapping, region rules and
// persistence filter over several register settings.
// ----------------------------------------------------------------------------
module tb_position_region_classifier_unit;

  localparam int POS_FRAC  = 16;
  localparam int PX        = 256;
  localparam int U_RIGHT   = 415;
  localparam int U_MID     = 300;
  localparam int V_UPPER   = 315;
  localparam int U_LOWER   = 300;
  localparam int V_LOWER   = 190;
  localparam int U_LEFTUP  = 245;
  localparam int V_LEFTUP  = 215;
  localparam int ELL_CU    = 285;
  localparam int ELL_CV    = 225;
  localparam int ELL_RU    = 52;
  localparam int ELL_RV    = 66;
  localparam int HOLD_AT   = 60;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic        cmd;
    logic        finite;
    logic [31:0] x;
    logic [31:0] y;
  } sample_t;

  typedef struct packed {
    prc_pkg::region_t raw;
    prc_pkg::region_t acc;
  } region_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [prc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [prc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                s_valid = 1'b0;
  logic                                s_ready;
  logic [prc_pkg::IN_TDATA_W-1:0]      s_data = '0;
  logic [prc_pkg::IN_TUSER_W-1:0]      s_user = '0;
  logic                                m_valid;
  logic                                m_ready = 1'b0;
  logic [prc_pkg::OUT_TDATA_W-1:0]     m_data;

  logic signed [31:0] cfg_org_e   = -32'sd997291;
  logic signed [31:0] cfg_org_n   = -32'sd204640;
  logic [15:0]        cfg_ppm     = 16'd5120;
  logic [11:0]        cfg_w       = 12'd615;
  logic [11:0]        cfg_h       = 12'd403;
  logic [7:0]         cfg_persist = 8'd5;

  prc_pkg::region_t filt_acc  = prc_pkg::REGION_UNKNOWN;
  prc_pkg::region_t filt_cand = prc_pkg::REGION_UNKNOWN;
  logic [7:0]       filt_count = 8'd0;
  logic             filt_started = 1'b0;

  sample_t      sample_q[$];
  region_pair_t expected_regions[$];
  sample_t      next_sample;

  int          errors = 0;
  int          results_seen = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned ready_gap = 0;
  int unsigned ready_calm = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  position_region_classifier_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic prc_pkg::region_t classify_position(input logic signed [31:0] px,
                                                         input logic signed [31:0] py);
    longint dx, dy, u, v, du, dv, lhs, rad;
    prc_pkg::region_t r;
    dx = longint'(px) - longint'(cfg_org_e);
    dy = longint'(py) - longint'(cfg_org_n);
    u = (dx * longint'(cfg_ppm)) >>> POS_FRAC;
    v = longint'(cfg_h) * PX - ((dy * longint'(cfg_ppm)) >>> POS_FRAC);
    if (u < 0 || u >= longint'(cfg_w) * PX || v < 0 || v >= longint'(cfg_h) * PX)
      return prc_pkg::REGION_UNKNOWN;
    r = prc_pkg::REGION_OTHER;
    if (u >= U_RIGHT * PX && v < V_UPPER * PX) r = prc_pkg::REGION_RIGHT;
    if (u >= U_MID * PX && u < U_RIGHT * PX && v < V_UPPER * PX) r = prc_pkg::REGION_MIDDLE;
    if (u < U_LOWER * PX && v >= V_LOWER * PX) r = prc_pkg::REGION_LEFT_LO;
    if (u < U_LEFTUP * PX && v < V_LEFTUP * PX) r = prc_pkg::REGION_LEFT_UP;
    du = (u - ELL_CU * PX) * ELL_RV;
    dv = (v - ELL_CV * PX) * ELL_RU;
    lhs = du * du + dv * dv;
    rad = longint'(ELL_RU) * ELL_RV * PX;
    if (lhs <= rad * rad) r = prc_pkg::REGION_DROP;
    return r;
  endfunction

  function automatic prc_pkg::region_t persist_filter(input prc_pkg::region_t raw);
    if (!filt_started) begin
      filt_started = 1'b1;
      filt_acc = raw;
      filt_cand = raw;
      filt_count = 8'd0;
      return filt_acc;
    end
    if (raw == filt_acc) begin
      filt_cand = filt_acc;
      filt_count = 8'd0;
      return filt_acc;
    end
    if (raw == filt_cand) begin
      if (filt_count != 8'hFF) filt_count = filt_count + 8'd1;
    end else begin
      filt_cand = raw;
      filt_count = 8'd1;
    end
    if (filt_count >= cfg_persist) begin
      filt_acc = filt_cand;
      filt_count = 8'd0;
    end
    return filt_acc;
  endfunction

  task automatic predict_sample(input logic [63:0] data, input logic [1:0] user);
    region_pair_t r;
    if (user[0]) begin
      filt_started = 1'b1;
      filt_acc = prc_pkg::REGION_UNKNOWN;
      filt_cand = prc_pkg::REGION_UNKNOWN;
      filt_count = 8'd0;
      r.raw = prc_pkg::REGION_UNKNOWN;
      r.acc = prc_pkg::REGION_UNKNOWN;
    end else begin
      r.raw = user[1] ? classify_position(data[31:0], data[63:32]) : prc_pkg::REGION_UNKNOWN;
      r.acc = persist_filter(r.raw);
    end
    expected_regions.push_back(r);
  endtask

  task automatic check_result(input logic [7:0] data);
    region_pair_t     want;
    prc_pkg::region_t got_raw;
    prc_pkg::region_t got_acc;
    got_raw = data[2:0];
    got_acc = data[5:3];
    results_seen++;
    if (expected_regions.size() == 0) begin
      if (errors < 10)
        $display("unexpected result %0d: raw %0d region %0d", results_seen, got_raw, got_acc);
      errors++;
    end else begin
      want = expected_regions.pop_front();
      if (want.raw != got_raw || want.acc != got_acc) begin
        if (errors < 10)
          $display("mismatch at result %0d: expected raw %0d region %0d, got raw %0d region %0d",
                   results_seen, want.raw, want.acc, got_raw, got_acc);
        errors++;
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      send_gap <= 0;
      send_calm <= 0;
    end else begin
      if (s_valid && s_ready) predict_sample(s_data, s_user);
      if (!s_valid || s_ready) begin
        if (send_gap != 0) begin
          s_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (sample_q.size() != 0) begin
          next_sample = sample_q.pop_front();
          s_valid <= 1'b1;
          s_data <= {next_sample.y, next_sample.x};
          s_user <= {next_sample.finite, next_sample.cmd};
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
          end else begin
            send_gap <= pick_gap();
            if ($urandom_range(0, 49) == 0) send_calm <= 40;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
      ready_gap <= 0;
      ready_calm <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_valid && m_ready) check_result(m_data);
      if (hold_left != 0) begin
        m_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        m_ready <= 1'b0;
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (ready_gap != 0) begin
        m_ready <= 1'b0;
        ready_gap <= ready_gap - 1;
      end else begin
        m_ready <= 1'b1;
        if (ready_calm != 0) begin
          ready_calm <= ready_calm - 1;
        end else begin
          ready_gap <= pick_gap();
          if ($urandom_range(0, 49) == 0) ready_calm <= 40;
        end
      end
    end
  end

  task automatic push_raw(input logic cmd, input logic finite,
                          input logic [31:0] x, input logic [31:0] y);
    sample_t s;
    s.cmd = cmd;
    s.finite = finite;
    s.x = x;
    s.y = y;
    sample_q.push_back(s);
  endtask

  // Builds a finite sample that lands near Q.8 pixel (u8, v8) under the current setting.
  task automatic push_pixel(input longint u8, input longint v8);
    longint dx, dy;
    dx = 0;
    dy = 0;
    if (cfg_ppm != 0) begin
      dx = (u8 <<< POS_FRAC) / longint'(cfg_ppm);
      dy = ((longint'(cfg_h) * PX - v8) <<< POS_FRAC) / longint'(cfg_ppm);
    end
    push_raw(1'b0, 1'b1, 32'(longint'(cfg_org_e) + dx), 32'(longint'(cfg_org_n) + dy));
  endtask

  function automatic longint center_pix(input int code, input bit vert);
    int u, v;
    case (code)
      1: begin u = 100; v = 100; end
      2: begin u = 100; v = 300; end
      3: begin u = ELL_CU; v = ELL_CV; end
      4: begin u = 350; v = 100; end
      5: begin u = 500; v = 100; end
      default: begin u = 500; v = 380; end
    endcase
    return longint'(vert ? v : u) * PX + 128;
  endfunction

  task automatic random_items(input int n);
    int     count, sel, len, run_max;
    longint u, v;
    count = 0;
    while (count < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 7) begin
        push_raw(1'b1, 1'($urandom_range(0, 1)), $urandom(), $urandom());
        count++;
      end else if (sel < 15) begin
        push_raw(1'b0, 1'b0, $urandom(), $urandom());
        count++;
      end else if (sel < 25) begin
        push_raw(1'b0, 1'b1, $urandom(), $urandom());
        count++;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          sel = $urandom_range(1, 6);
          u = center_pix(sel, 1'b0);
          v = center_pix(sel, 1'b1);
        end else if (sel < 8) begin
          u = (cfg_w == 0) ? 0 : longint'($urandom_range(0, int'(cfg_w) * PX - 1));
          v = (cfg_h == 0) ? 0 : longint'($urandom_range(0, int'(cfg_h) * PX - 1));
        end else begin
          case ($urandom_range(0, 4))
            0: u = U_LEFTUP;
            1: u = U_MID;
            2: u = U_RIGHT;
            3: u = ELL_CU + ELL_RU;
            default: u = cfg_w;
          endcase
          case ($urandom_range(0, 4))
            0: v = V_LOWER;
            1: v = V_LEFTUP;
            2: v = V_UPPER;
            3: v = ELL_CV + ELL_RV;
            default: v = cfg_h;
          endcase
          u = u * PX + longint'($urandom_range(0, 4)) - 2;
          v = v * PX + longint'($urandom_range(0, 4)) - 2;
        end
        run_max = int'(cfg_persist) + 2;
        if (run_max > 10) run_max = 10;
        len = $urandom_range(1, run_max);
        repeat (len) begin
          push_pixel(u + longint'($urandom_range(0, 64)) - 32,
                     v + longint'($urandom_range(0, 64)) - 32);
        end
        count += len;
      end
    end
  endtask

  task automatic write_reg(input logic [prc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prc_pkg::REG_ORIGIN_EAST:  cfg_org_e = val;
      prc_pkg::REG_ORIGIN_NORTH: cfg_org_n = val;
      prc_pkg::REG_PPM:          cfg_ppm = val[15:0];
      prc_pkg::REG_MAP_WIDTH:    cfg_w = val[11:0];
      prc_pkg::REG_MAP_HEIGHT:   cfg_h = val[11:0];
      prc_pkg::REG_PERSIST:      cfg_persist = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] org_e, input logic [31:0] org_n,
                            input logic [15:0] ppm, input logic [11:0] w,
                            input logic [11:0] h, input logic [7:0] persist);
    write_reg(prc_pkg::REG_ORIGIN_EAST, org_e);
    write_reg(prc_pkg::REG_ORIGIN_NORTH, org_n);
    write_reg(prc_pkg::REG_PPM, {16'd0, ppm});
    write_reg(prc_pkg::REG_MAP_WIDTH, {20'd0, w});
    write_reg(prc_pkg::REG_MAP_HEIGHT, {20'd0, h});
    write_reg(prc_pkg::REG_PERSIST, {24'd0, persist});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_valid || expected_regions.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first sample is taken over directly, then a new region has to persist.
    push_pixel(center_pix(5, 1'b0), center_pix(5, 1'b1));
    push_pixel(center_pix(5, 1'b0), center_pix(5, 1'b1));
    repeat (6) push_pixel(center_pix(4, 1'b0), center_pix(4, 1'b1));
    push_raw(1'b1, 1'b0, $urandom(), $urandom());
    push_pixel(center_pix(1, 1'b0), center_pix(1, 1'b1));
    push_pixel(center_pix(2, 1'b0), center_pix(2, 1'b1));
    push_pixel(center_pix(3, 1'b0), center_pix(3, 1'b1));
    push_pixel(center_pix(6, 1'b0), center_pix(6, 1'b1));
    push_raw(1'b0, 1'b0, 32'h0000_0000, $urandom());
    push_pixel(-1, 100 * PX);
    push_pixel(longint'(cfg_w) * PX, 100 * PX);
    push_pixel(100 * PX, longint'(cfg_h) * PX);
    push_raw(1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    push_raw(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_pixel((ELL_CU + ELL_RU) * PX, ELL_CV * PX);
    push_pixel(U_RIGHT * PX, V_UPPER * PX - 1);
    push_pixel(U_MID * PX - 1, V_LOWER * PX);
    push_pixel(U_LEFTUP * PX - 1, V_LEFTUP * PX - 1);
    push_raw(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_raw(1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
    drain();

    set_config(32'sd1000000, -32'sd3000000, 16'd256, 12'd4095, 12'd4095, 8'd1);
    random_items(50);
    drain();

    // Slowest acceptance: a region must repeat until the count saturates.
    set_config(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 12'd615, 12'd403, 8'd255);
    random_items(20);
    push_raw(1'b1, 1'b0, $urandom(), $urandom());
    repeat (258) push_pixel(center_pix(5, 1'b0), center_pix(5, 1'b1));
    drain();

    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 12'd615, 12'd403, 8'd0);
    random_items(15);
    drain();

    set_config(-32'sd997291, -32'sd204640, 16'd5120, 12'd0, 12'd0, 8'd2);
    random_items(15);
    drain();

    set_config(-32'sd997291, -32'sd204640, 16'd5120, 12'd615, 12'd403, 8'd0);
    random_items(20);
    drain();

    set_config(32'h0000_0000, 32'h0000_0000, 16'd1, 12'd1, 12'd1, 8'd3);
    random_items(15);
    drain();

    set_config(-32'sd997291, -32'sd204640, 16'd5120, 12'd615, 12'd403, 8'd5);
    random_items(20);
    drain();

    if (errors == 0 && expected_regions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: position_region_classifier_unit.f
rtl/core/prc_pkg.sv
rtl/core/position_region_classifier_unit.sv
rtl/core/prc_checker.sv
bench/tb_position_region_classifier_unit.sv
